// ===== hw/rtl/coordinate_hash_table_defines.svh =====
// assertion macros for the coordinate hash table
`ifndef COORDINATE_HASH_TABLE_DEFINES_SVH
`define COORDINATE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CHT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CHT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cht_pkg.sv =====
`timescale 1ns / 1ps

package cht_pkg;

	localparam int BUCKETS  = 1013;
	localparam int WAYS     = 4;
	localparam int COORD_W  = 32;
	localparam int VALUE_W  = 31;
	localparam int RESULT_W = 32;

	localparam int IDX_W    = $clog2(BUCKETS);
	localparam int FILL_W   = $clog2(WAYS + 1);
	localparam int REM_W    = IDX_W + 1;

	// reciprocal for the bucket remainder, estimate is low by at most one
	localparam int          RECIP_SH = 31 + IDX_W;
	localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / BUCKETS;
	localparam logic [31:0] RECIP_32 = RECIP[31:0];

	localparam logic [31:0] HASH_MIX = 32'd3506;
	localparam logic [31:0] HASH_X   = 32'd1435;
	localparam logic [31:0] HASH_Z   = 32'd15;

	// request modes
	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		entry_t [WAYS-1:0]  way;
		logic [FILL_W-1:0]  fill;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH1,
		ST_HASH2,
		ST_HASH3,
		ST_HASH4,
		ST_READ,
		ST_CMP
	} state_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic rd_en;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
	} status_t;

endpackage

// ===== hw/rtl/cht_ram.sv =====
`timescale 1ns / 1ps

module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/cht_hash.sv =====
`timescale 1ns / 1ps

module cht_hash (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cht_pkg::COORD_W-1:0] x,
	input  logic [cht_pkg::COORD_W-1:0] z,
	output logic [cht_pkg::IDX_W-1:0]   bucket
);

	import cht_pkg::*;

	logic [31:0]      mix_s1;
	logic [31:0]      px_s1;
	logic [31:0]      pz_s1;
	logic [31:0]      h;
	logic [31:0]      mag;
	logic [31:0]      mag_s2;
	logic [63:0]      prod;
	logic [REM_W-1:0] q_s3;
	logic [REM_W-1:0] mag_s3;
	logic [REM_W-1:0] qb_s4;
	logic [REM_W-1:0] mag_s4;
	logic [REM_W-1:0] r;
	logic [IDX_W-1:0] bucket_s5;

	// constant products
	always_ff @(posedge clk) begin
		if (en) begin
			mix_s1 <= 32'((x ^ z) * HASH_MIX);
			px_s1  <= 32'(x * HASH_X);
			pz_s1  <= 32'(z * HASH_Z);
		end
	end

	// combine and take magnitude
	assign h   = 32'(px_s1 + pz_s1) ^ mix_s1;
	assign mag = h[31] ? 32'(~h + 32'd1) : h;

	always_ff @(posedge clk) begin
		mag_s2 <= mag;
	end

	// quotient estimate, only its low bits matter
	assign prod = 64'(mag_s2) * 64'(RECIP_32);

	always_ff @(posedge clk) begin
		q_s3   <= prod[RECIP_SH +: REM_W];
		mag_s3 <= mag_s2[REM_W-1:0];
	end

	always_ff @(posedge clk) begin
		qb_s4  <= REM_W'(q_s3 * REM_W'(BUCKETS));
		mag_s4 <= mag_s3;
	end

	// remainder below twice the bucket count, one correction
	assign r = REM_W'(mag_s4 - qb_s4);

	always_ff @(posedge clk) begin
		if (r >= REM_W'(BUCKETS)) begin
			bucket_s5 <= IDX_W'(REM_W'(r - REM_W'(BUCKETS)));
		end else begin
			bucket_s5 <= IDX_W'(r);
		end
	end

	assign bucket = bucket_s5;

endmodule

// ===== hw/rtl/cht_datapath.sv =====
`timescale 1ns / 1ps

module cht_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cht_pkg::cmd_t                       cmd,
	output cht_pkg::status_t                    status,
	input  logic                                mode,
	input  logic signed [cht_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [cht_pkg::COORD_W-1:0]  z_coord,
	input  logic [cht_pkg::VALUE_W-1:0]         new_value,
	output logic                                found,
	output logic signed [cht_pkg::RESULT_W-1:0] result_value,
	output logic                                dropped
);

	import cht_pkg::*;

	logic                mode_q;
	logic [COORD_W-1:0]  x_q;
	logic [COORD_W-1:0]  z_q;
	logic [VALUE_W-1:0]  val_q;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    bucket;
	logic [ROW_W-1:0]    rd_data;
	row_t                rd_row;
	row_t                wr_row;
	logic                hit;
	logic [VALUE_W-1:0]  hit_val;
	logic                full;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [ROW_W-1:0]    wr_data;
	logic                found_q;
	logic [RESULT_W-1:0] result_q;
	logic                dropped_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			x_q    <= x_coord;
			z_q    <= z_coord;
			val_q  <= new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr && !status.clr_done) begin
			clr_q <= IDX_W'(clr_q + 1'b1);
		end
	end

	assign status.clr_done = (clr_q == IDX_W'(BUCKETS - 1));

	cht_hash u_hash (
		.clk    (clk),
		.en     (cmd.load),
		.x      (x_coord),
		.z      (z_coord),
		.bucket (bucket)
	);

	cht_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BUCKETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (bucket),
		.rd_data (rd_data)
	);

	assign rd_row = row_t'(rd_data);
	assign full   = (rd_row.fill >= FILL_W'(WAYS));

	// earliest matching way wins
	always_comb begin
		hit     = 1'b0;
		hit_val = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (FILL_W'(i) < rd_row.fill && rd_row.way[i].x == x_q
					&& rd_row.way[i].z == z_q) begin
				hit     = 1'b1;
				hit_val = rd_row.way[i].value;
			end
		end
	end

	// append at the fill position
	always_comb begin
		wr_row      = rd_row;
		wr_row.fill = FILL_W'(rd_row.fill + 1'b1);
		for (int i = 0; i < WAYS; i++) begin
			if (FILL_W'(i) == rd_row.fill) begin
				wr_row.way[i].x     = x_q;
				wr_row.way[i].z     = z_q;
				wr_row.way[i].value = val_q;
			end
		end
	end

	assign wr_en   = cmd.clr_wr || (cmd.commit && mode_q == MODE_INSERT && !full);
	assign wr_addr = cmd.clr_wr ? clr_q : bucket;
	assign wr_data = cmd.clr_wr ? '0 : ROW_W'(wr_row);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			found_q   <= (mode_q == MODE_LOOKUP) && hit;
			result_q  <= ((mode_q == MODE_LOOKUP) && hit) ? {1'b0, hit_val} : '1;
			dropped_q <= (mode_q == MODE_INSERT) && full;
		end
	end

	assign found        = found_q;
	assign result_value = result_q;
	assign dropped      = dropped_q;

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
`timescale 1ns / 1ps

module cht_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output cht_pkg::cmd_t    cmd,
	input  cht_pkg::status_t status
);

	import cht_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (status.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_HASH1;
				end
			end
			ST_HASH1: state_d = ST_HASH2;
			ST_HASH2: state_d = ST_HASH3;
			ST_HASH3: state_d = ST_HASH4;
			ST_HASH4: state_d = ST_READ;
			ST_READ:  state_d = ST_CMP;
			ST_CMP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_READ:  cmd.rd_en = 1'b1;
			ST_CMP:   cmd.commit = !out_valid_q || !out_stall;
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/coordinate_hash_table.sv =====
`timescale 1ns / 1ps

// Hash table of (x, z) coordinate keys holding 31-bit area indexes, with up to
// WAYS entries per bucket kept in one row of a single-port-read bucket memory.
// One beat is worked on at a time: after an input beat is taken the block works
// through the bucket hash (constant products, magnitude, reciprocal multiply
// and remainder correction), the synchronous row read and the way compare or
// append write, and it takes no next input beat until it is through with the
// previous one; the result beat is shown in the cycle after the compare.
// A result still waiting on out_stall holds only the compare
// step of the following beat. After reset the fill counts are cleared by a pass
// over all BUCKETS rows, one row a cycle, with in_stall held high.

module coordinate_hash_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                mode,
	input  logic signed [cht_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [cht_pkg::COORD_W-1:0]  z_coord,
	input  logic [cht_pkg::VALUE_W-1:0]         new_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                found,
	output logic signed [cht_pkg::RESULT_W-1:0] result_value,
	output logic                                dropped
);

	import cht_pkg::*;

	cmd_t    cmd;
	status_t status;

	cht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	cht_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.x_coord      (x_coord),
		.z_coord      (z_coord),
		.new_value    (new_value),
		.found        (found),
		.result_value (result_value),
		.dropped      (dropped)
	);

endmodule

// ===== hw/rtl/cht_checker.sv =====
`timescale 1ns / 1ps

`include "coordinate_hash_table_defines.svh"

module cht_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                found,
	input logic signed [cht_pkg::RESULT_W-1:0] result_value,
	input logic                                dropped
);

	`CHT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped while stalled")

	`CHT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(found) && $stable(result_value) && $stable(dropped), "stalled result beat changed")

	`CHT_ASSERT_NOW(a_flags_excl, out_valid, !(found && dropped), "found and dropped both set")

	`CHT_ASSERT_NOW(a_miss_value, out_valid && !found, result_value == 32'hFFFF_FFFF, "miss or insert without all-ones value")

	`CHT_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "input beat taken while one is in work")

endmodule

bind coordinate_hash_table cht_checker u_cht_checker (.*);

// ===== bench/cht_checker.sv =====
`timescale 1ns / 1ps

module cht_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        mode,
	input  logic [31:0] x_coord,
	input  logic [31:0] z_coord,
	input  logic [30:0] new_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        found,
	input  logic [31:0] result_value,
	input  logic        dropped,
	output int          mismatches,
	output int          pending
);

	import cht_pkg::*;

	localparam logic [31:0] MIX_MUL     = 32'd3506;
	localparam logic [31:0] X_MUL       = 32'd1435;
	localparam logic [31:0] Z_MUL       = 32'd15;
	localparam logic [31:0] NO_VALUE    = 32'hFFFF_FFFF;
	localparam int          SLOT_COUNT  = cht_pkg::BUCKETS * cht_pkg::WAYS;

	typedef struct packed {
		logic        found;
		logic [31:0] value;
		logic        dropped;
	} table_reply_t;

	int unsigned  fill_count [cht_pkg::BUCKETS];
	logic [31:0]  slot_x [SLOT_COUNT];
	logic [31:0]  slot_z [SLOT_COUNT];
	logic [30:0]  slot_value [SLOT_COUNT];
	table_reply_t replies_due [$];

	function automatic int unsigned hash_bucket(input logic [31:0] x, input logic [31:0] z);
		logic [31:0] mix;
		logic [31:0] h;
		logic [31:0] mag;
		mix = (x ^ z) * MIX_MUL;
		h   = (x * X_MUL + z * Z_MUL) ^ mix;
		mag = h[31] ? (32'd0 - h) : h;
		return mag % 32'(cht_pkg::BUCKETS);
	endfunction

	function automatic table_reply_t apply_request(input logic m, input logic [31:0] x,
		input logic [31:0] z, input logic [30:0] v);
		table_reply_t reply;
		int unsigned  b;
		int unsigned  base;
		int unsigned  fill;
		int unsigned  i;
		reply.found   = 1'b0;
		reply.value   = NO_VALUE;
		reply.dropped = 1'b0;
		b    = hash_bucket(x, z);
		base = b * cht_pkg::WAYS;
		fill = fill_count[b];
		if (m == MODE_INSERT) begin
			if (fill >= cht_pkg::WAYS) begin
				reply.dropped = 1'b1;
			end else begin
				slot_x[base + fill]     = x;
				slot_z[base + fill]     = z;
				slot_value[base + fill] = v;
				fill_count[b]           = fill + 1;
			end
		end else if (m == MODE_LOOKUP) begin
			for (i = 0; i < fill; i++) begin
				if (!reply.found && slot_x[base + i] == x && slot_z[base + i] == z) begin
					reply.found = 1'b1;
					reply.value = {1'b0, slot_value[base + i]};
				end
			end
		end
		return reply;
	endfunction

	initial begin
		mismatches = 0;
		pending    = 0;
		foreach (fill_count[i]) fill_count[i] = 0;
	end

	always @(posedge clk) begin : watch
		table_reply_t want;
		table_reply_t due;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$display("%t unexpected beat: expected none, got found %0b value %0h dropped %0b",
						$time, found, result_value, dropped);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					if (found !== want.found) begin
						$display("%t found: expected %0b, got %0b", $time, want.found, found);
						mismatches++;
					end
					if (result_value !== want.value) begin
						$display("%t result_value: expected %0h, got %0h", $time, want.value,
							result_value);
						mismatches++;
					end
					if (dropped !== want.dropped) begin
						$display("%t dropped: expected %0b, got %0b", $time, want.dropped, dropped);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				due         = apply_request(mode, x_coord, z_coord, new_value);
				replies_due = {replies_due, due};
			end
			pending <= replies_due.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import cht_pkg::*;

	localparam logic [31:0] MIX_MUL        = 32'd3506;
	localparam logic [31:0] X_MUL          = 32'd1435;
	localparam logic [31:0] Z_MUL          = 32'd15;
	localparam int          HOT_BUCKETS    = 32;
	localparam int          HOT_KEYS       = 6;
	localparam int          RANDOM_ITEMS   = 930;
	localparam int          HOLD_AFTER     = 400;
	localparam int          HOLD_CYCLES    = 500;
	localparam int          WATCHDOG_LIMIT = 5000;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic                                mode;
	logic signed [cht_pkg::COORD_W-1:0]  x_coord;
	logic signed [cht_pkg::COORD_W-1:0]  z_coord;
	logic [cht_pkg::VALUE_W-1:0]         new_value;
	logic                                out_valid;
	logic                                out_stall;
	logic                                found;
	logic signed [cht_pkg::RESULT_W-1:0] result_value;
	logic                                dropped;

	int mismatches;
	int pending;
	int sent_count;
	int quiet_cycles = 0;

	logic [31:0] hot_x [HOT_BUCKETS][HOT_KEYS];
	logic [31:0] hot_z [HOT_BUCKETS][HOT_KEYS];
	logic [63:0] stored_keys [$];

	always #2 clk = ~clk;

	coordinate_hash_table u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.x_coord      (x_coord),
		.z_coord      (z_coord),
		.new_value    (new_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.result_value (result_value),
		.dropped      (dropped)
	);

	cht_scoreboard u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.x_coord      (x_coord),
		.z_coord      (z_coord),
		.new_value    (new_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.result_value (result_value),
		.dropped      (dropped),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	// used only to steer keys into shared buckets
	function automatic int unsigned bucket_of_key(input logic [31:0] x, input logic [31:0] z);
		logic [31:0] h;
		h = (x * X_MUL + z * Z_MUL) ^ ((x ^ z) * MIX_MUL);
		if (h[31])
			h = 32'd0 - h;
		return h % 32'(cht_pkg::BUCKETS);
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic m, input logic [31:0] x, input logic [31:0] z,
		input logic [30:0] v, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		x_coord   <= x;
		z_coord   <= z;
		new_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("coordinate_hash_table: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : receiver
		int  rounds;
		bit  held;
		out_stall = 1'b0;
		rounds    = 0;
		held      = 1'b0;
		@(posedge clk);
		forever begin
			rounds++;
			if (!held && sent_count >= HOLD_AFTER) begin
				// long hold so the block backs up into its input
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (rounds % 12 == 0) begin
				out_stall <= 1'b0;
				repeat (120) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (pause_len() + 1) @(posedge clk);
				out_stall <= 1'b0;
				repeat (pause_len() + 1) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned target;
		logic [31:0] cx;
		logic [31:0] cz;
		logic [31:0] rx;
		logic [31:0] rz;
		logic [63:0] key;
		int          r;
		int          hb;
		int          hk;
		int          gap;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		mode       = MODE_LOOKUP;
		x_coord    = '0;
		z_coord    = '0;
		new_value  = '0;
		sent_count = 0;

		// groups of distinct keys sharing a bucket, half sharing x, half sharing z
		for (int b = 0; b < HOT_BUCKETS; b++) begin
			hot_x[b][0] = $urandom;
			hot_z[b][0] = $urandom;
			target = bucket_of_key(hot_x[b][0], hot_z[b][0]);
			for (int k = 1; k < HOT_KEYS; k++) begin
				hot_x[b][k] = hot_x[b][0];
				hot_z[b][k] = hot_z[b][0];
				for (int t = 0; t < 20000; t++) begin
					cx = (k % 2) ? hot_x[b][0] : $urandom;
					cz = (k % 2) ? $urandom : hot_z[b][0];
					if (bucket_of_key(cx, cz) == target) begin
						hot_x[b][k] = cx;
						hot_z[b][k] = cz;
						break;
					end
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// empty table, most negative hash, extreme keys and values
		send_beat(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF, pause_len());
		send_beat(MODE_INSERT, 32'h8000_0000, 32'h0000_0000, 31'h0000_0000, pause_len());
		send_beat(MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 31'h0000_0000, pause_len());
		send_beat(MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, pause_len());
		send_beat(MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 31'h0000_0001, pause_len());
		send_beat(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h5555_5555, pause_len());
		send_beat(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h2AAA_AAAA, pause_len());
		send_beat(MODE_LOOKUP, 32'h8000_0000, 32'h8000_0000, 31'h0000_0000, pause_len());
		send_beat(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, pause_len());
		send_beat(MODE_LOOKUP, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0000_0000, pause_len());

		// duplicates of one key until its bucket overflows
		for (int i = 0; i < cht_pkg::WAYS + 1; i++)
			send_beat(MODE_INSERT, 32'h1234_5678, 32'hEDCB_A987, 31'(i * 100 + 7), pause_len());
		send_beat(MODE_LOOKUP, 32'h1234_5678, 32'hEDCB_A987, 31'h0, pause_len());

		// distinct keys in one bucket, overflow, hit deep in the row, miss in a full row
		for (int i = 0; i < cht_pkg::WAYS + 1; i++)
			send_beat(MODE_INSERT, hot_x[0][i], hot_z[0][i], 31'($urandom), pause_len());
		send_beat(MODE_LOOKUP, hot_x[0][3], hot_z[0][3], 31'($urandom), pause_len());
		send_beat(MODE_LOOKUP, hot_x[0][5], hot_z[0][5], 31'($urandom), pause_len());

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			gap = ((n % 200) < 40) ? 0 : pause_len();
			r   = $urandom_range(0, 99);
			hb  = $urandom_range(0, HOT_BUCKETS - 1);
			hk  = $urandom_range(0, HOT_KEYS - 1);
			if (stored_keys.size() > 0)
				key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
			else
				key = {$urandom, $urandom};
			if (r < 30) begin
				send_beat(MODE_INSERT, hot_x[hb][hk], hot_z[hb][hk], 31'($urandom), gap);
			end else if (r < 50) begin
				send_beat(MODE_LOOKUP, hot_x[hb][hk], hot_z[hb][hk], 31'($urandom), gap);
			end else if (r < 65) begin
				rx          = $urandom;
				rz          = $urandom;
				key         = {rx, rz};
				stored_keys = {stored_keys, key};
				send_beat(MODE_INSERT, rx, rz, 31'($urandom), gap);
			end else if (r < 80) begin
				send_beat(MODE_LOOKUP, key[63:32], key[31:0], 31'($urandom), gap);
			end else if (r < 85) begin
				send_beat(MODE_INSERT, key[63:32], key[31:0], 31'($urandom), gap);
			end else if (r < 92) begin
				send_beat(MODE_LOOKUP, $urandom, $urandom, 31'($urandom), gap);
			end else begin
				send_beat(MODE_LOOKUP, key[63:32], $urandom, 31'($urandom), gap);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("coordinate_hash_table: match");
		else
			$display("coordinate_hash_table: mismatch");
		$finish;
	end

endmodule

// ===== coordinate_hash_table.f =====
+incdir+hw/rtl
hw/rtl/cht_pkg.sv
hw/rtl/cht_ram.sv
hw/rtl/cht_hash.sv
hw/rtl/cht_datapath.sv
hw/rtl/cht_ctrl.sv
hw/rtl/coordinate_hash_table.sv
hw/rtl/cht_checker.sv
bench/cht_checker.sv
bench/tb.sv
